// File: sv/mie_pkg.sv
// ----------------------------------------------------------------------------
// MIPS instruction execute package
// Opcode, function and sequencer definitions shared by the execute block.
// ----------------------------------------------------------------------------
`default_nettype none

package mie_pkg;

  // Primary opcodes.
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_SLTIU   = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2B;

  // Function codes of the special opcode.
  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_SLLV    = 6'h04;
  localparam logic [5:0] FN_SRLV    = 6'h06;
  localparam logic [5:0] FN_SRAV    = 6'h07;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MTHI    = 6'h11;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MTLO    = 6'h13;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_MULTU   = 6'h19;
  localparam logic [5:0] FN_DIV     = 6'h1A;
  localparam logic [5:0] FN_DIVU    = 6'h1B;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2A;
  localparam logic [5:0] FN_SLTU    = 6'h2B;

  // Branch selectors of the regimm opcode.
  localparam logic [4:0] RT_BLTZ    = 5'h00;
  localparam logic [4:0] RT_BGEZ    = 5'h01;
  localparam logic [4:0] RT_BLTZAL  = 5'h10;
  localparam logic [4:0] RT_BGEZAL  = 5'h11;

  localparam logic [4:0]  REG_V0    = 5'd2;
  localparam logic [4:0]  REG_RA    = 5'd31;
  localparam logic [31:0] EXIT_CODE = 32'd10;
  localparam int          REG_COUNT = 32;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_DIVEND,
    ST_MRD,
    ST_MACC,
    ST_FIN
  } state_t;

  // What the execute cycle hands on to.
  typedef enum logic [1:0] {
    K_DONE,
    K_MEM,
    K_DIV
  } kind_t;

endpackage

`default_nettype wire

// File: sv/mips_instruction_execute.sv
// ----------------------------------------------------------------------------
// MIPS instruction execute
// Executes one MIPS32 integer instruction word per item against a register
// file, HI/LO and a word data memory, and reports the next PC and any write.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake               Payload
//  -------   ---------  ----------------------  --------------------------------
//  in        into       in_valid / in_stall     instr_word
//  out       out of     out_valid / out_stall   next_pc, wrote_reg, dest_index,
//                                               dest_value, overflow_seen,
//                                               misaligned, halted
//  cfg       into       cfg_we                  cfg_wdata (start PC)
//
// Sequence: a plain ALU, shift, branch, jump or multiply word passes from
// acceptance through register file read, execute and output load. Aligned
// loads and stores add a memory read and a memory access step when DMEM_WORDS
// is a power of two; otherwise the word index is first reduced modulo
// DMEM_WORDS in the shared divider. div and divu run the same restoring
// divider for 32 iterations. Only one word is in flight at a time.
// After reset, a clearing pass writes zero to every register file and data
// memory entry, one per cycle; no word is accepted meanwhile. A stalled
// output holds the finished word, and a new word may be accepted while it
// waits; its result is held back until the slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module mips_instruction_execute
  import mie_pkg::*;
#(
  parameter int DMEM_WORDS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] instr_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      next_pc,
  output logic             wrote_reg,
  output logic [4:0]       dest_index,
  output logic [31:0]      dest_value,
  output logic             overflow_seen,
  output logic             misaligned,
  output logic             halted
);

  // Data memory index width and the clearing sweep covering both stores.
  localparam int  AW       = $clog2(DMEM_WORDS);
  localparam int  CLR_LEN  = (DMEM_WORDS > REG_COUNT) ? DMEM_WORDS : REG_COUNT;
  localparam int  CW       = $clog2(CLR_LEN);
  localparam bit  DM_POW2  = ((DMEM_WORDS & (DMEM_WORDS - 1)) == 0);
  localparam logic [31:0] DM_DEN = 32'(DMEM_WORDS);

  state_t state, state_next;

  logic [CW-1:0] clr_cnt;
  logic          clr_dm, clr_rf;

  logic [31:0] pc;
  logic [31:0] hi, lo;
  logic [31:0] iw;

  // Registered results waiting for the output slot.
  logic [31:0] res_npc;
  logic        res_wr;
  logic [4:0]  res_idx;
  logic [31:0] res_val;
  logic        res_ovf, res_mis, res_halt;

  // Memory access context.
  logic [31:0]   addr_q;
  logic [31:0]   store_q;
  logic [AW-1:0] mem_idx;

  // Shared divider state.
  logic [31:0] dv_rem, dv_quo, dv_den;
  logic [4:0]  dv_cnt;
  logic        dv_addr_mode, dv_na, dv_nb;
  logic [32:0] dv_sh;
  logic [33:0] dv_diff;

  // Register file: two copies written together give two read ports.
  logic        rf_we;
  logic [4:0]  rf_waddr;
  logic [31:0] rf_wdata;
  logic [4:0]  rf_raddr_a, rf_raddr_b;
  logic [31:0] rf_a_q, rf_b_q;

  logic          dm_we;
  logic [AW-1:0] dm_waddr;
  logic [31:0]   dm_wdata;
  logic [31:0]   dm_rdata;

  // Execute-cycle decode and results.
  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sa;
  logic [15:0] imm;
  logic [31:0] a, b, simm, pc4, btarget, jtarget, addr;
  logic [31:0] sum, dif, sumi;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic        mul_sg;
  logic [31:0] x_npc, x_wval, x_hi, x_lo;
  logic [4:0]  x_widx;
  logic        x_wreq, x_ovf, x_mis, x_halt, x_hi_we, x_lo_we, x_div_start;
  kind_t       x_kind;

  // Memory access cycle results.
  logic [31:0] m_word, m_val, m_store, m_mask;
  logic [4:0]  m_sh;
  logic        m_wreq;

  logic out_free;
  logic in_take;

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign op   = iw[31:26];
  assign rs   = iw[25:21];
  assign rt   = iw[20:16];
  assign rd   = iw[15:11];
  assign sa   = iw[10:6];
  assign fn   = iw[5:0];
  assign imm  = iw[15:0];

  // The syscall exit test needs v0, which is read on the rs port.
  always_comb begin
    if (instr_word[31:26] == OP_SPECIAL && instr_word[5:0] == FN_SYSCALL) begin
      rf_raddr_a = REG_V0;
    end else begin
      rf_raddr_a = instr_word[25:21];
    end
    rf_raddr_b = instr_word[20:16];
  end

  assign a       = (rs == 5'd0) ? 32'd0 : rf_a_q;
  assign b       = (rt == 5'd0) ? 32'd0 : rf_b_q;
  assign simm    = {{16{imm[15]}}, imm};
  assign pc4     = pc + 32'd4;
  assign btarget = pc4 + {simm[29:0], 2'b00};
  assign jtarget = {pc4[31:28], iw[25:0], 2'b00};
  assign addr    = a + simm;
  assign sum     = a + b;
  assign dif     = a - b;
  assign sumi    = a + simm;

  // One 33x33 signed multiplier serves both mult and multu.
  assign mul_sg = (fn == FN_MULT);
  assign mul_a  = $signed({mul_sg & a[31], a});
  assign mul_b  = $signed({mul_sg & b[31], b});
  assign prod   = mul_a * mul_b;

  always_comb begin
    x_npc       = pc4;
    x_wreq      = 1'b0;
    x_widx      = rd;
    x_wval      = 32'd0;
    x_ovf       = 1'b0;
    x_mis       = 1'b0;
    x_halt      = 1'b0;
    x_hi_we     = 1'b0;
    x_lo_we     = 1'b0;
    x_hi        = prod[63:32];
    x_lo        = prod[31:0];
    x_div_start = 1'b0;
    x_kind      = K_DONE;
    case (op)
      OP_SPECIAL: begin
        case (fn)
          FN_SLL:  begin x_wreq = 1'b1; x_wval = b << sa; end
          FN_SRL:  begin x_wreq = 1'b1; x_wval = b >> sa; end
          FN_SRA:  begin x_wreq = 1'b1; x_wval = 32'($signed(b) >>> sa); end
          FN_SLLV: begin x_wreq = 1'b1; x_wval = b << a[4:0]; end
          FN_SRLV: begin x_wreq = 1'b1; x_wval = b >> a[4:0]; end
          FN_SRAV: begin x_wreq = 1'b1; x_wval = 32'($signed(b) >>> a[4:0]); end
          FN_JR:   x_npc = a;
          FN_JALR: begin x_npc = a; x_wreq = 1'b1; x_wval = pc4; end
          FN_SYSCALL: x_halt = (rf_a_q == EXIT_CODE);
          FN_MFHI: begin x_wreq = 1'b1; x_wval = hi; end
          FN_MTHI: begin x_hi_we = 1'b1; x_hi = a; end
          FN_MFLO: begin x_wreq = 1'b1; x_wval = lo; end
          FN_MTLO: begin x_lo_we = 1'b1; x_lo = a; end
          FN_MULT, FN_MULTU: begin
            x_hi_we = 1'b1;
            x_lo_we = 1'b1;
          end
          FN_DIV, FN_DIVU: begin
            if (b == 32'd0) begin
              // Divide by zero clears both halves.
              x_hi_we = 1'b1;
              x_lo_we = 1'b1;
              x_hi    = 32'd0;
              x_lo    = 32'd0;
            end else begin
              x_div_start = 1'b1;
              x_kind      = K_DIV;
            end
          end
          FN_ADD: begin
            x_ovf  = (a[31] ^ sum[31]) & (b[31] ^ sum[31]);
            x_wreq = !x_ovf;
            x_wval = sum;
          end
          FN_ADDU: begin x_wreq = 1'b1; x_wval = sum; end
          FN_SUB: begin
            x_ovf  = (a[31] ^ b[31]) & (a[31] ^ dif[31]);
            x_wreq = !x_ovf;
            x_wval = dif;
          end
          FN_SUBU: begin x_wreq = 1'b1; x_wval = dif; end
          FN_AND:  begin x_wreq = 1'b1; x_wval = a & b; end
          FN_OR:   begin x_wreq = 1'b1; x_wval = a | b; end
          FN_XOR:  begin x_wreq = 1'b1; x_wval = a ^ b; end
          FN_NOR:  begin x_wreq = 1'b1; x_wval = ~(a | b); end
          FN_SLT:  begin x_wreq = 1'b1; x_wval = {31'd0, $signed(a) < $signed(b)}; end
          FN_SLTU: begin x_wreq = 1'b1; x_wval = {31'd0, a < b}; end
          default: ;
        endcase
      end
      OP_REGIMM: begin
        case (rt)
          RT_BLTZ, RT_BLTZAL: begin
            if (rt == RT_BLTZAL) begin
              x_wreq = 1'b1; x_widx = REG_RA; x_wval = pc4;
            end
            if (a[31]) x_npc = btarget;
          end
          RT_BGEZ, RT_BGEZAL: begin
            if (rt == RT_BGEZAL) begin
              x_wreq = 1'b1; x_widx = REG_RA; x_wval = pc4;
            end
            if (!a[31]) x_npc = btarget;
          end
          default: ;
        endcase
      end
      OP_J:    x_npc = jtarget;
      OP_JAL:  begin
        x_npc = jtarget; x_wreq = 1'b1; x_widx = REG_RA; x_wval = pc4;
      end
      OP_BEQ:  if (a == b) x_npc = btarget;
      OP_BNE:  if (a != b) x_npc = btarget;
      OP_BLEZ: if (a[31] || a == 32'd0) x_npc = btarget;
      OP_BGTZ: if (!a[31] && a != 32'd0) x_npc = btarget;
      OP_ADDI: begin
        x_widx = rt;
        x_ovf  = (a[31] ^ sumi[31]) & (simm[31] ^ sumi[31]);
        x_wreq = !x_ovf;
        x_wval = sumi;
      end
      OP_ADDIU: begin x_widx = rt; x_wreq = 1'b1; x_wval = sumi; end
      OP_SLTI: begin
        x_widx = rt; x_wreq = 1'b1; x_wval = {31'd0, $signed(a) < $signed(simm)};
      end
      OP_SLTIU: begin x_widx = rt; x_wreq = 1'b1; x_wval = {31'd0, a < simm}; end
      OP_ANDI: begin x_widx = rt; x_wreq = 1'b1; x_wval = a & {16'd0, imm}; end
      OP_ORI:  begin x_widx = rt; x_wreq = 1'b1; x_wval = a | {16'd0, imm}; end
      OP_XORI: begin x_widx = rt; x_wreq = 1'b1; x_wval = a ^ {16'd0, imm}; end
      OP_LUI:  begin x_widx = rt; x_wreq = 1'b1; x_wval = {imm, 16'd0}; end
      OP_LB, OP_LBU, OP_SB: x_kind = K_MEM;
      OP_LH, OP_LHU, OP_SH: begin
        x_mis  = addr[0];
        x_kind = addr[0] ? K_DONE : K_MEM;
      end
      OP_LW, OP_SW: begin
        x_mis  = (addr[1:0] != 2'b00);
        x_kind = x_mis ? K_DONE : K_MEM;
      end
      default: ;
    endcase
  end

  // Restoring divider step: one quotient bit per cycle.
  assign dv_sh   = {dv_rem, dv_quo[31]};
  assign dv_diff = {1'b0, dv_sh} - {2'b00, dv_den};

  // Load extraction and store merge on the registered memory word.
  assign m_word = dm_rdata;
  assign m_sh   = {addr_q[1:0], 3'b000};
  always_comb begin
    m_wreq  = 1'b0;
    m_val   = 32'd0;
    m_mask  = 32'd0;
    m_store = m_word;
    case (op)
      OP_LB:  begin m_wreq = 1'b1; m_val = 32'($signed(m_word[m_sh +: 8])); end
      OP_LBU: begin m_wreq = 1'b1; m_val = {24'd0, m_word[m_sh +: 8]}; end
      OP_LH:  begin
        m_wreq = 1'b1;
        m_val  = 32'($signed(addr_q[1] ? m_word[31:16] : m_word[15:0]));
      end
      OP_LHU: begin
        m_wreq = 1'b1;
        m_val  = {16'd0, addr_q[1] ? m_word[31:16] : m_word[15:0]};
      end
      OP_LW:  begin m_wreq = 1'b1; m_val = m_word; end
      OP_SB:  begin
        m_mask  = 32'h0000_00FF << m_sh;
        m_store = (m_word & ~m_mask) | ({24'd0, store_q[7:0]} << m_sh);
      end
      OP_SH:  begin
        m_mask  = 32'h0000_FFFF << {addr_q[1], 4'b0000};
        m_store = (m_word & ~m_mask) | ({16'd0, store_q[15:0]} << {addr_q[1], 4'b0000});
      end
      OP_SW:  m_store = store_q;
      default: ;
    endcase
  end

  assign clr_rf = (state == ST_CLEAR) && ({1'b0, clr_cnt} < (CW + 1)'(REG_COUNT));
  assign clr_dm = (state == ST_CLEAR) && ({1'b0, clr_cnt} < (CW + 1)'(DMEM_WORDS));

  // Register file write port: clearing pass, execute cycle or load return.
  always_comb begin
    rf_we    = 1'b0;
    rf_waddr = x_widx;
    rf_wdata = x_wval;
    if (state == ST_CLEAR) begin
      rf_we    = clr_rf;
      rf_waddr = clr_cnt[4:0];
      rf_wdata = 32'd0;
    end else if (state == ST_EXEC) begin
      rf_we    = x_wreq && (x_widx != 5'd0);
    end else if (state == ST_MACC) begin
      rf_we    = m_wreq && (rt != 5'd0);
      rf_waddr = rt;
      rf_wdata = m_val;
    end
  end

  always_comb begin
    if (state == ST_CLEAR) begin
      dm_we    = clr_dm;
      dm_waddr = clr_cnt[AW-1:0];
      dm_wdata = 32'd0;
    end else begin
      dm_we    = (state == ST_MACC) && (op == OP_SB || op == OP_SH || op == OP_SW);
      dm_waddr = mem_idx;
      dm_wdata = m_store;
    end
  end

  mie_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (rf_raddr_a),
    .rdata (rf_a_q)
  );

  mie_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (rf_raddr_b),
    .rdata (rf_b_q)
  );

  mie_ram #(.WIDTH(32), .DEPTH(DMEM_WORDS)) u_dmem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .raddr (mem_idx),
    .rdata (dm_rdata)
  );

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (clr_cnt == CW'(CLR_LEN - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (in_take) state_next = ST_EXEC;
      ST_EXEC: begin
        case (x_kind)
          K_DIV:   state_next = ST_DIV;
          K_MEM:   state_next = DM_POW2 ? ST_MRD : ST_DIV;
          default: state_next = ST_FIN;
        endcase
      end
      ST_DIV:    if (dv_cnt == 5'd0) state_next = ST_DIVEND;
      ST_DIVEND: state_next = dv_addr_mode ? ST_MRD : ST_FIN;
      ST_MRD:    state_next = ST_MACC;
      ST_MACC:   state_next = ST_FIN;
      ST_FIN:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == ST_CLEAR) begin
      clr_cnt <= clr_cnt + CW'(1);
    end
  end

  // Architectural state: PC, HI and LO. A start PC write loads the PC.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= 32'h0040_0000;
      hi       <= 32'd0;
      lo       <= 32'd0;
    end else begin
      if (cfg_we) begin
        pc       <= cfg_wdata;
      end else if (state == ST_EXEC) begin
        pc <= x_npc;
      end
      if (state == ST_EXEC) begin
        if (x_hi_we) hi <= x_hi;
        if (x_lo_we) lo <= x_lo;
      end else if (state == ST_DIVEND && !dv_addr_mode) begin
        lo <= (dv_na != dv_nb) ? (32'd0 - dv_quo) : dv_quo;
        hi <= dv_na ? (32'd0 - dv_rem) : dv_rem;
      end
    end
  end

  // Word, result and memory context registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      iw <= instr_word;
    end
    if (state == ST_EXEC) begin
      res_npc  <= x_npc;
      res_wr   <= x_wreq && (x_widx != 5'd0);
      res_idx  <= (x_wreq && (x_widx != 5'd0)) ? x_widx : 5'd0;
      res_val  <= (x_wreq && (x_widx != 5'd0)) ? x_wval : 32'd0;
      res_ovf  <= x_ovf;
      res_mis  <= x_mis;
      res_halt <= x_halt;
      addr_q   <= addr;
      store_q  <= b;
      mem_idx  <= addr[AW+1:2];
    end else if (state == ST_DIVEND && dv_addr_mode) begin
      mem_idx  <= dv_rem[AW-1:0];
    end else if (state == ST_MACC) begin
      res_wr   <= m_wreq && (rt != 5'd0);
      res_idx  <= (m_wreq && (rt != 5'd0)) ? rt : 5'd0;
      res_val  <= (m_wreq && (rt != 5'd0)) ? m_val : 32'd0;
    end
  end

  // Shared divider: signed/unsigned divide, or the data memory word index
  // modulo DMEM_WORDS when that is not a power of two.
  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      dv_rem <= 32'd0;
      dv_cnt <= 5'd31;
      if (x_div_start) begin
        dv_addr_mode <= 1'b0;
        dv_na        <= (fn == FN_DIV) && a[31];
        dv_nb        <= (fn == FN_DIV) && b[31];
        dv_quo       <= ((fn == FN_DIV) && a[31]) ? (32'd0 - a) : a;
        dv_den       <= ((fn == FN_DIV) && b[31]) ? (32'd0 - b) : b;
      end else begin
        dv_addr_mode <= 1'b1;
        dv_na        <= 1'b0;
        dv_nb        <= 1'b0;
        dv_quo       <= {2'b00, addr[31:2]};
        dv_den       <= DM_DEN;
      end
    end else if (state == ST_DIV) begin
      dv_cnt <= dv_cnt - 5'd1;
      if (!dv_diff[33]) begin
        dv_rem <= dv_diff[31:0];
        dv_quo <= {dv_quo[30:0], 1'b1};
      end else begin
        dv_rem <= dv_sh[31:0];
        dv_quo <= {dv_quo[30:0], 1'b0};
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      next_pc       <= res_npc;
      wrote_reg     <= res_wr;
      dest_index    <= res_idx;
      dest_value    <= res_val;
      overflow_seen <= res_ovf;
      misaligned    <= res_mis;
      halted        <= res_halt;
    end
  end

endmodule

`default_nettype wire

// File: sv/mie_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
